// ===== rtl/tdts_pkg.sv =====
`timescale 1ns / 1ps
package tdts_pkg;

  localparam int MaxLexemeDefault  = 255;
  localparam int QueueDepthDefault = 4;

  localparam int NumStates  = 9;
  localparam int NumClasses = 13;

  // Character classes
  localparam logic [3:0] ClsLetter  = 4'd0;
  localparam logic [3:0] ClsDigit   = 4'd1;
  localparam logic [3:0] ClsDot     = 4'd2;
  localparam logic [3:0] ClsPlus    = 4'd3;
  localparam logic [3:0] ClsMinus   = 4'd4;
  localparam logic [3:0] ClsStar    = 4'd5;
  localparam logic [3:0] ClsSlash   = 4'd6;
  localparam logic [3:0] ClsCaret   = 4'd7;
  localparam logic [3:0] ClsEqual   = 4'd8;
  localparam logic [3:0] ClsBlank   = 4'd9;
  localparam logic [3:0] ClsNewline = 4'd10;
  localparam logic [3:0] ClsEnd     = 4'd11;
  localparam logic [3:0] ClsOther   = 4'd12;

  localparam logic [3:0] StateStart = 4'd0;

  // Stop codes of the transition table
  localparam logic [7:0] StopBase  = 8'd100;
  localparam logic [7:0] StopIdent = 8'd100;
  localparam logic [7:0] StopConst = 8'd101;
  localparam logic [7:0] StopPlus  = 8'd102;
  localparam logic [7:0] StopMinus = 8'd104;
  localparam logic [7:0] StopStar  = 8'd106;
  localparam logic [7:0] StopSlash = 8'd108;
  localparam logic [7:0] StopEnd   = 8'd112;
  localparam logic [7:0] StopError = 8'd200;

  localparam logic [3:0] KindError = 4'd14;

  localparam logic [7:0] NextTab [0:NumStates-1][0:NumClasses-1] = '{
    '{8'd1,   8'd2,   8'd3,   8'd5,   8'd6,   8'd7,   8'd8,   8'd110, 8'd111,
      8'd0,   8'd113, 8'd112, 8'd200},
    '{8'd1,   8'd1,   8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100,
      8'd100, 8'd100, 8'd100, 8'd100},
    '{8'd101, 8'd2,   8'd4,   8'd101, 8'd101, 8'd101, 8'd101, 8'd101, 8'd101,
      8'd101, 8'd101, 8'd101, 8'd101},
    '{8'd200, 8'd4,   8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200,
      8'd200, 8'd200, 8'd200, 8'd200},
    '{8'd101, 8'd4,   8'd200, 8'd101, 8'd101, 8'd101, 8'd101, 8'd101, 8'd101,
      8'd101, 8'd101, 8'd101, 8'd101},
    '{8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd103,
      8'd102, 8'd102, 8'd102, 8'd102},
    '{8'd104, 8'd104, 8'd104, 8'd104, 8'd104, 8'd104, 8'd104, 8'd104, 8'd105,
      8'd104, 8'd104, 8'd104, 8'd104},
    '{8'd106, 8'd106, 8'd106, 8'd106, 8'd106, 8'd106, 8'd106, 8'd106, 8'd107,
      8'd106, 8'd106, 8'd106, 8'd106},
    '{8'd108, 8'd108, 8'd108, 8'd108, 8'd108, 8'd108, 8'd108, 8'd108, 8'd109,
      8'd108, 8'd108, 8'd108, 8'd108}
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } in_word_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] lexeme_length;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] lexeme_length;
  } tok_t;

  // Tokens caused by one character: one or two
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } rec_t;

endpackage

// ===== rtl/tdts_front.sv =====
`timescale 1ns / 1ps
module tdts_front #(
  parameter int MaxLexeme = tdts_pkg::MaxLexemeDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tdts_pkg::in_word_t in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output tdts_pkg::rec_t     rec_o
);

  localparam int CntW = $clog2(MaxLexeme + 1);

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic [3:0]      cls;
  logic [3:0]      st0;
  logic [7:0]      code0, code1;
  logic            emit;

  function automatic logic [3:0] classify(input logic [7:0] ch, input logic is_end);
    logic [3:0] c;
    if (is_end) begin
      c = tdts_pkg::ClsEnd;
    end else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
      c = tdts_pkg::ClsLetter;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      c = tdts_pkg::ClsDigit;
    end else begin
      case (ch)
        8'h2E:               c = tdts_pkg::ClsDot;
        8'h2B:               c = tdts_pkg::ClsPlus;
        8'h2D:               c = tdts_pkg::ClsMinus;
        8'h2A:               c = tdts_pkg::ClsStar;
        8'h2F:               c = tdts_pkg::ClsSlash;
        8'h5E:               c = tdts_pkg::ClsCaret;
        8'h3D:               c = tdts_pkg::ClsEqual;
        8'h20, 8'h09, 8'h0D: c = tdts_pkg::ClsBlank;
        8'h0A:               c = tdts_pkg::ClsNewline;
        default:             c = tdts_pkg::ClsOther;
      endcase
    end
    return c;
  endfunction

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] n);
    return (32'(n) < MaxLexeme) ? n + CntW'(1) : CntW'(MaxLexeme);
  endfunction

  function automatic logic [7:0] shown_len(input logic [CntW-1:0] n);
    return (32'(n) > 32'd255) ? 8'hFF : 8'(n);
  endfunction

  function automatic logic [3:0] kind_of(input logic [7:0] code);
    logic [7:0] k;
    k = code - tdts_pkg::StopBase;
    return (code == tdts_pkg::StopError) ? tdts_pkg::KindError : k[3:0];
  endfunction

  function automatic logic leaves_out(input logic [7:0] code);
    return code == tdts_pkg::StopIdent || code == tdts_pkg::StopConst ||
           code == tdts_pkg::StopPlus  || code == tdts_pkg::StopMinus ||
           code == tdts_pkg::StopStar  || code == tdts_pkg::StopSlash;
  endfunction

  assign accept = in_valid_i && !full_i;
  assign cls    = classify(in_data_i.char_code, in_data_i.end_mark);
  // Treat a state outside the table as the start state
  assign st0    = (state_q > 4'd8) ? tdts_pkg::StateStart : state_q;
  assign code0  = tdts_pkg::NextTab[st0][cls];
  assign code1  = tdts_pkg::NextTab[tdts_pkg::StateStart][cls];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    rec_o   = '0;
    if (code0 < tdts_pkg::StopBase) begin
      state_d = code0[3:0];
      if (!(st0 == tdts_pkg::StateStart && cls == tdts_pkg::ClsBlank)) begin
        cnt_d = bump(cnt_q);
      end
    end else if (leaves_out(code0)) begin
      // Close the pending token, rescan the character from the start state
      emit                    = 1'b1;
      rec_o.tok0.token_kind    = kind_of(code0);
      rec_o.tok0.lexeme_length = shown_len(cnt_q);
      if (code1 < tdts_pkg::StopBase) begin
        state_d = code1[3:0];
        cnt_d   = (cls == tdts_pkg::ClsBlank) ? '0 : CntW'(1);
      end else begin
        state_d                  = tdts_pkg::StateStart;
        cnt_d                    = '0;
        rec_o.two                = 1'b1;
        rec_o.tok1.token_kind    = kind_of(code1);
        rec_o.tok1.lexeme_length =
          (in_data_i.end_mark || code1 == tdts_pkg::StopEnd) ? 8'd0 : 8'd1;
      end
    end else begin
      emit                     = 1'b1;
      state_d                  = tdts_pkg::StateStart;
      cnt_d                    = '0;
      rec_o.tok0.token_kind    = kind_of(code0);
      rec_o.tok0.lexeme_length =
        (in_data_i.end_mark || code0 == tdts_pkg::StopEnd) ? shown_len(cnt_q)
                                                           : shown_len(bump(cnt_q));
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdts_pkg::StateStart;
      cnt_q   <= '0;
    end else if (accept) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/tdts_queue.sv =====
`timescale 1ns / 1ps
module tdts_queue #(
  parameter int Depth = tdts_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tdts_pkg::rec_t rec_i,
  input  logic           pop_i,
  output tdts_pkg::rec_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tdts_pkg::rec_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("record pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("record popped from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= Depth)
    else $error("queue count beyond depth");

endmodule

// ===== rtl/tdts_back.sv =====
`timescale 1ns / 1ps
module tdts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdts_pkg::rec_t      head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tdts_pkg::out_word_t out_data_o
);

  logic                valid_q, valid_d;
  logic                second_q, second_d;
  tdts_pkg::out_word_t out_q, out_d;
  logic                load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    out_d    = out_q;
    pop_o    = 1'b0;
    if (load) begin
      if (second_q) begin
        // Second token of the head record, then drop the record
        out_d.token_kind    = head_i.tok1.token_kind;
        out_d.lexeme_length = head_i.tok1.lexeme_length;
        out_d.last          = 1'b1;
        valid_d             = 1'b1;
        second_d            = 1'b0;
        pop_o               = 1'b1;
      end else if (!empty_i) begin
        out_d.token_kind    = head_i.tok0.token_kind;
        out_d.lexeme_length = head_i.tok0.lexeme_length;
        out_d.last          = !head_i.two;
        valid_d             = 1'b1;
        second_d            = head_i.two;
        pop_o               = !head_i.two;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  a_second_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (!empty_i && head_i.two))
    else $error("second token pending without a two-token record");

  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(second_q) |-> (valid_q && !out_q.last))
    else $error("first of two tokens not marked as non-last");

endmodule

// ===== rtl/table_driven_token_scanner_top.sv =====
`timescale 1ns / 1ps
// Token scanner: takes one character word per cycle (or an end-of-text mark) and
// returns token words {kind, length, last}. A character is accepted in the cycle
// it is offered while the record queue (QueueDepth records) has room; the scan
// state advances through one table lookup per character, or two on a rescan from
// the start state. A character that closes a token and then forms another by
// itself yields two token words, which leave the output register one after the
// other while the output is not stalled, so the output side moves at most one
// token word per cycle. Each token word passes the queue and the output register.
// Characters that only extend a lexeme, and blanks between tokens, produce no word.
module table_driven_token_scanner_top #(
  parameter int MaxLexeme  = tdts_pkg::MaxLexemeDefault,
  parameter int QueueDepth = tdts_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tdts_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tdts_pkg::out_word_t out_data_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  tdts_pkg::rec_t rec;
  tdts_pkg::rec_t head;

  assign in_stall_o = full;

  tdts_front #(
    .MaxLexeme(MaxLexeme)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .rec_o     (rec)
  );

  tdts_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  tdts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef enum logic [3:0] {
    TokIdent, TokConst, TokPlus, TokPlusEq, TokMinus, TokMinusEq, TokStar, TokStarEq,
    TokSlash, TokSlashEq, TokCaret, TokEqual, TokEnd, TokNewline, TokError
  } token_kind_e;

  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChNl    = 8'h0A;

  localparam int RandomChars = 1350;
  localparam int DrainCycles = 20;

  // Next state per (state, class); 100 and up close a token
  localparam logic [7:0] ScanNext [0:8][0:12] = '{
    '{  1,   2,   3,   5,   6,   7,   8, 110, 111,   0, 113, 112, 200},
    '{  1,   1, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100, 100},
    '{101,   2,   4, 101, 101, 101, 101, 101, 101, 101, 101, 101, 101},
    '{200,   4, 200, 200, 200, 200, 200, 200, 200, 200, 200, 200, 200},
    '{101,   4, 200, 101, 101, 101, 101, 101, 101, 101, 101, 101, 101},
    '{102, 102, 102, 102, 102, 102, 102, 102, 103, 102, 102, 102, 102},
    '{104, 104, 104, 104, 104, 104, 104, 104, 105, 104, 104, 104, 104},
    '{106, 106, 106, 106, 106, 106, 106, 106, 107, 106, 106, 106, 106},
    '{108, 108, 108, 108, 108, 108, 108, 108, 109, 108, 108, 108, 108}
  };

  function automatic logic [3:0] char_class(logic [7:0] c, logic em);
    if (em) return tdts_pkg::ClsEnd;
    if ((c >= ChUpA && c <= ChUpA + 25) || (c >= ChLoA && c <= ChLoA + 25))
      return tdts_pkg::ClsLetter;
    if (c >= ChZero && c <= ChZero + 9) return tdts_pkg::ClsDigit;
    case (c)
      ChDot:                 return tdts_pkg::ClsDot;
      ChPlus:                return tdts_pkg::ClsPlus;
      ChMinus:               return tdts_pkg::ClsMinus;
      ChStar:                return tdts_pkg::ClsStar;
      ChSlash:               return tdts_pkg::ClsSlash;
      ChCaret:               return tdts_pkg::ClsCaret;
      ChEqual:               return tdts_pkg::ClsEqual;
      ChSpace, ChTab, ChCr:  return tdts_pkg::ClsBlank;
      ChNl:                  return tdts_pkg::ClsNewline;
      default:               return tdts_pkg::ClsOther;
    endcase
  endfunction

  function automatic int unsigned bump_count(int unsigned n);
    return (n < tdts_pkg::MaxLexemeDefault) ? n + 1 : tdts_pkg::MaxLexemeDefault;
  endfunction

  class token_scoreboard;
    tdts_pkg::out_word_t expected_tokens[$];
    logic [3:0]          scan_st = tdts_pkg::StateStart;
    int unsigned         lex_cnt = 0;
    int unsigned         n_err   = 0;

    function void note_fail(string msg);
      n_err++;
      if (n_err <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Run one accepted character word through the scan and queue its tokens
    function void add_char(tdts_pkg::in_word_t w);
      logic [3:0]          cls;
      logic [3:0]          st;
      logic [7:0]          code;
      int unsigned         len;
      bit                  left_out;
      tdts_pkg::out_word_t toks [2];
      int                  n;
      cls = char_class(w.char_code, w.end_mark);
      n = 0;
      for (int p = 0; p < 2; p++) begin
        st = (scan_st < tdts_pkg::NumStates) ? scan_st : tdts_pkg::StateStart;
        code = ScanNext[st][cls];
        if (code < tdts_pkg::StopBase) begin
          if (!(st == tdts_pkg::StateStart && cls == tdts_pkg::ClsBlank))
            lex_cnt = bump_count(lex_cnt);
          scan_st = code[3:0];
          break;
        end
        left_out = code inside {tdts_pkg::StopIdent, tdts_pkg::StopConst,
                                tdts_pkg::StopPlus, tdts_pkg::StopMinus,
                                tdts_pkg::StopStar, tdts_pkg::StopSlash};
        len = lex_cnt;
        if (!left_out && !w.end_mark && code != tdts_pkg::StopEnd) len = bump_count(len);
        toks[n].token_kind    = (code == tdts_pkg::StopError) ? TokError :
                                token_kind_e'(4'(code - tdts_pkg::StopBase));
        toks[n].lexeme_length = (len > 255) ? 8'd255 : len[7:0];
        toks[n].last          = 1'b0;
        n++;
        scan_st = tdts_pkg::StateStart;
        lex_cnt = 0;
        // rescan the character from the start state only when it was left out
        if (!left_out) break;
      end
      for (int i = 0; i < n; i++) begin
        toks[i].last = (i == n - 1);
        expected_tokens.push_back(toks[i]);
      end
    endfunction

    function void check_token(tdts_pkg::out_word_t got);
      tdts_pkg::out_word_t want;
      if (expected_tokens.size() == 0) begin
        note_fail($sformatf("unexpected token word: kind %0d len %0d last %0b",
                            got.token_kind, got.lexeme_length, got.last));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.lexeme_length !== want.lexeme_length ||
          got.last !== want.last)
        note_fail($sformatf({"token word kind %0d len %0d last %0b, ",
                             "expected kind %0d len %0d last %0b"},
                            got.token_kind, got.lexeme_length, got.last,
                            want.token_kind, want.lexeme_length, want.last));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  tdts_pkg::in_word_t  in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  tdts_pkg::out_word_t out_data_o;

  token_scoreboard sb = new();

  int chars_sent   = 0;
  int in_calm_left = 0;
  int stall_left   = 0;
  int stall_pick;
  bit stall_now    = 1'b0;
  bit long_seen    = 1'b0;

  table_driven_token_scanner_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Check accepted token words and pick the next stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_token(out_data_o);
      if (stall_left == 0) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 25) begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(1, 3);
        end else if (stall_pick < 29) begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(10, 40);
        end else if (stall_pick < 33) begin
          stall_now  = 1'b0;
          stall_left = $urandom_range(100, 300);
        end else begin
          stall_now  = 1'b0;
          stall_left = $urandom_range(1, 8);
        end
      end
      stall_left--;
      out_stall_i <= stall_now;
    end
  end

  function automatic int in_gap();
    int pick;
    if (in_calm_left > 0) begin
      in_calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    if (pick < 98) return $urandom_range(20, 60);
    in_calm_left = $urandom_range(40, 120);
    return 0;
  endfunction

  task automatic put_char(tdts_pkg::in_word_t w);
    int gap;
    gap = in_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.add_char(w);
    chars_sent++;
  endtask

  task automatic put_byte(logic [7:0] c);
    put_char(tdts_pkg::in_word_t'({c, 1'b0}));
  endtask

  task automatic put_end();
    put_char(tdts_pkg::in_word_t'({8'($urandom_range(0, 255)), 1'b1}));
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_digits(int n);
    for (int i = 0; i < n; i++) put_byte(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_ident();
    int n;
    if ((!long_seen && chars_sent > 400) || $urandom_range(0, 79) == 0) begin
      n = $urandom_range(250, 300);
      long_seen = 1'b1;
    end else begin
      n = $urandom_range(1, 8);
    end
    put_byte(($urandom_range(0, 1) ? ChUpA : ChLoA) + 8'($urandom_range(0, 25)));
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       put_byte(ChUpA + 8'($urandom_range(0, 25)));
        1:       put_byte(ChLoA + 8'($urandom_range(0, 25)));
        default: put_byte(ChZero + 8'($urandom_range(0, 9)));
      endcase
    end
  endtask

  task automatic put_number();
    case ($urandom_range(0, 5))
      0, 1: put_digits($urandom_range(1, 6));
      2: begin
        put_digits($urandom_range(1, 4));
        put_byte(ChDot);
        put_digits($urandom_range(1, 4));
      end
      3: begin
        put_byte(ChDot);
        put_digits($urandom_range(1, 4));
      end
      4: begin
        put_digits($urandom_range(1, 3));
        put_byte(ChDot);
      end
      default: begin
        // malformed: second dot, or dot with no digits
        if ($urandom_range(0, 1)) begin
          put_digits($urandom_range(0, 3));
          put_byte(ChDot);
          put_digits($urandom_range(1, 3));
          put_byte(ChDot);
        end else begin
          put_byte(ChDot);
        end
      end
    endcase
  endtask

  task automatic put_random_token();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      put_ident();
    end else if (pick < 42) begin
      put_number();
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0:       put_byte(ChPlus);
        1:       put_byte(ChMinus);
        2:       put_byte(ChStar);
        default: put_byte(ChSlash);
      endcase
      if ($urandom_range(0, 1)) put_byte(ChEqual);
    end else if (pick < 66) begin
      put_byte($urandom_range(0, 1) ? ChCaret : ChEqual);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       put_byte(ChSpace);
          1:       put_byte(ChTab);
          default: put_byte(ChCr);
        endcase
      end
    end else if (pick < 86) begin
      put_byte(ChNl);
    end else if (pick < 90) begin
      put_end();
    end else if (pick < 95) begin
      do c = 8'($urandom_range(0, 255)); while (char_class(c, 1'b0) != tdts_pkg::ClsOther);
      put_byte(c);
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every token kind but plus-equal, two-token words, errors, end handling
    put_text("Z9\n");
    put_text("1.5+-");
    put_text("=*=");
    put_text("/=/^");
    put_text("*");
    put_byte(8'h00);
    put_text(".7-\t");
    put_text(".");
    put_end();
    put_end();
    put_text("=");
    put_text("3.");
    put_byte(8'h80);

    chars_sent = 0;
    while (chars_sent < RandomChars) put_random_token();
    in_valid_i <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.n_err == 0 && sb.expected_tokens.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== table_driven_token_scanner_top.f =====
rtl/tdts_pkg.sv
rtl/tdts_front.sv
rtl/tdts_queue.sv
rtl/tdts_back.sv
rtl/table_driven_token_scanner_top.sv
sim/tb.sv
